### design/u16d_pkg.sv
// Package for the UTF-16 byte stream decoder: constants and result types.
// Used by the interfaces, the core, the output buffer and the top level.
`default_nettype none

package u16d_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned UNIT_W = 16;
    localparam int unsigned CP_W   = 21;
    localparam int unsigned SIZE_W = 3;

    // surrogate prefixes: the top six bits of a 16-bit unit
    localparam logic [5:0] LEAD_PREFIX  = 6'b110110;   // 0xD800..0xDBFF
    localparam logic [5:0] TRAIL_PREFIX = 6'b110111;   // 0xDC00..0xDFFF

    localparam logic [CP_W-1:0]   SUPPL_BASE = 21'h10000;
    localparam logic [SIZE_W-1:0] SIZE_UNIT  = 3'd2;
    localparam logic [SIZE_W-1:0] SIZE_PAIR  = 3'd4;

    // output buffer depth: one pending result plus the two a byte can cause
    localparam int unsigned OBUF_DEPTH = 3;

    typedef struct packed {
        logic [CP_W-1:0]   code_point;
        logic [SIZE_W-1:0] size_bytes;
        logic              malformed;
        logic              last;
    } t_result;

    // results caused by one accepted byte, in order: res0 then res1
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_push;

endpackage

`default_nettype wire

### design/u16d_if.sv
// Channel interfaces of the decoder: byte input, result output, config write.
// Depends on u16d_pkg for field widths.
`default_nettype none

interface u16d_in_if;
    logic                          valid;
    logic                          ready;
    logic [u16d_pkg::BYTE_W-1:0]   data_byte;
    logic                          end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface u16d_out_if;
    logic                          valid;
    logic                          ready;
    logic [u16d_pkg::CP_W-1:0]     code_point;
    logic [u16d_pkg::SIZE_W-1:0]   size_bytes;
    logic                          malformed;
    logic                          last;

    modport source (output valid, output code_point, output size_bytes, output malformed,
                    output last, input ready);
    modport sink   (input valid, input code_point, input size_bytes, input malformed,
                    input last, output ready);
endinterface

interface u16d_cfg_if;
    logic valid;
    logic ready;
    logic big_endian;

    modport source (output valid, output big_endian, input ready);
    modport sink   (input valid, input big_endian, output ready);
endinterface

`default_nettype wire

### design/utf16_byte_stream_decoder.sv
// UTF-16 byte stream decoder, top level. A result enters the result queue when
// the byte that completes it is accepted. Throughput: one byte per cycle while
// the queue has room; the two results of one byte leave one after the other,
// set by the single output port draining the result queue.
// Reset: synchronous, active low; clears stream state, the result queue and
// big_endian (low byte first).
`default_nettype none

module utf16_byte_stream_decoder #(
    parameter int unsigned OBUF_DEPTH = u16d_pkg::OBUF_DEPTH
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    u16d_in_if.sink     i_in,
    u16d_out_if.source  o_out,
    u16d_cfg_if.sink    i_cfg
);

    u16d_pkg::t_push    push;
    u16d_pkg::t_result  head;
    logic               room;
    logic               accept;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = room;
    assign accept      = i_in.valid && room;

    u16d_core u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg.valid),
        .i_cfg_big_endian (i_cfg.big_endian),
        .i_accept         (accept),
        .i_data_byte      (i_in.data_byte),
        .i_end_of_stream  (i_in.end_of_stream),
        .o_push           (push)
    );

    u16d_obuf #(
        .DEPTH (OBUF_DEPTH)
    ) u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (o_out.ready),
        .o_room  (room),
        .o_valid (o_out.valid),
        .o_head  (head)
    );

    assign o_out.code_point = head.code_point;
    assign o_out.size_bytes = head.size_bytes;
    assign o_out.malformed  = head.malformed;
    assign o_out.last       = head.last;

endmodule

`default_nettype wire

### design/u16d_core.sv
// Decoder core: byte pairing, surrogate handling and the config register.
// Depends on u16d_pkg; produces up to two results per accepted byte.
`default_nettype none

module u16d_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic                        i_cfg_big_endian,
    input  wire logic                        i_accept,
    input  wire logic [u16d_pkg::BYTE_W-1:0] i_data_byte,
    input  wire logic                        i_end_of_stream,
    output u16d_pkg::t_push                  o_push
);

    logic                          r_big_endian;
    logic                          r_byte_phase, n_byte_phase;
    logic [u16d_pkg::BYTE_W-1:0]   r_first_byte, n_first_byte;
    logic                          r_lead_held, n_lead_held;
    logic [9:0]                    r_lead_bits, n_lead_bits;

    logic [u16d_pkg::UNIT_W-1:0]   unit;
    logic                          is_lead, is_trail;
    u16d_pkg::t_result             lead_res, unit_res, pair_res;
    u16d_pkg::t_push               push;

    assign unit = r_big_endian ? {r_first_byte, i_data_byte} : {i_data_byte, r_first_byte};
    assign is_lead  = (unit[15:10] == u16d_pkg::LEAD_PREFIX);
    assign is_trail = (unit[15:10] == u16d_pkg::TRAIL_PREFIX);

    always_comb begin
        lead_res.code_point = {5'd0, u16d_pkg::LEAD_PREFIX, r_lead_bits};
        lead_res.size_bytes = u16d_pkg::SIZE_UNIT;
        lead_res.malformed  = 1'b1;
        lead_res.last       = 1'b0;

        unit_res.code_point = {5'd0, unit};
        unit_res.size_bytes = u16d_pkg::SIZE_UNIT;
        unit_res.malformed  = 1'b0;
        unit_res.last       = 1'b0;

        pair_res.code_point = u16d_pkg::SUPPL_BASE + {1'b0, r_lead_bits, unit[9:0]};
        pair_res.size_bytes = u16d_pkg::SIZE_PAIR;
        pair_res.malformed  = 1'b0;
        pair_res.last       = 1'b0;
    end

    always_comb begin
        n_byte_phase = r_byte_phase;
        n_first_byte = r_first_byte;
        n_lead_held  = r_lead_held;
        n_lead_bits  = r_lead_bits;
        push         = '0;
        push.res0    = unit_res;
        push.res1    = unit_res;

        if (!r_byte_phase) begin
            n_byte_phase = 1'b1;
            n_first_byte = i_data_byte;
        end else begin
            n_byte_phase = 1'b0;
            n_first_byte = '0;
            if (r_lead_held && is_trail) begin
                n_lead_held = 1'b0;
                n_lead_bits = '0;
                push.res0   = pair_res;
                push.count  = 2'd1;
            end else begin
                if (r_lead_held) begin
                    push.res0  = lead_res;
                    push.count = 2'd1;
                end
                if (is_lead) begin
                    n_lead_held = 1'b1;
                    n_lead_bits = unit[9:0];
                end else begin
                    n_lead_held = 1'b0;
                    n_lead_bits = '0;
                    if (r_lead_held) begin
                        push.res1  = unit_res;
                        push.count = 2'd2;
                    end else begin
                        push.res0  = unit_res;
                        push.count = 2'd1;
                    end
                end
            end
        end

        if (i_end_of_stream) begin
            // flush whatever lead is held after this byte
            if (n_lead_held) begin
                if (push.count == 2'd0) begin
                    push.res0 = lead_res;
                    push.res0.code_point = {5'd0, u16d_pkg::LEAD_PREFIX, n_lead_bits};
                end else begin
                    push.res1 = lead_res;
                    push.res1.code_point = {5'd0, u16d_pkg::LEAD_PREFIX, n_lead_bits};
                end
                push.count = push.count + 2'd1;
            end
            n_byte_phase = 1'b0;
            n_first_byte = '0;
            n_lead_held  = 1'b0;
            n_lead_bits  = '0;
        end

        if (push.count == 2'd1) begin
            push.res0.last = 1'b1;
        end
        if (push.count == 2'd2) begin
            push.res1.last = 1'b1;
        end
        if (!i_accept) begin
            push.count = 2'd0;
        end
    end

    assign o_push = push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_big_endian <= 1'b0;
            r_byte_phase <= 1'b0;
            r_first_byte <= '0;
            r_lead_held  <= 1'b0;
            r_lead_bits  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_big_endian <= i_cfg_big_endian;
            end
            if (i_accept) begin
                r_byte_phase <= n_byte_phase;
                r_first_byte <= n_first_byte;
                r_lead_held  <= n_lead_held;
                r_lead_bits  <= n_lead_bits;
            end
        end
    end

endmodule

`default_nettype wire

### design/u16d_obuf.sv
// Result buffer: a short shift queue that takes up to two results a cycle
// and hands one a cycle to the output while it is ready. Depends on u16d_pkg.
`default_nettype none

module u16d_obuf #(
    parameter int unsigned DEPTH = u16d_pkg::OBUF_DEPTH
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire u16d_pkg::t_push i_push,
    input  wire logic            i_pop,
    output logic                 o_room,
    output logic                 o_valid,
    output u16d_pkg::t_result    o_head
);

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    u16d_pkg::t_result r_slot [DEPTH];
    u16d_pkg::t_result n_slot [DEPTH];
    logic [CNT_W-1:0]  r_cnt, n_cnt, base;
    logic              pop;

    assign pop     = i_pop && (r_cnt != '0);
    assign base    = r_cnt - CNT_W'(pop);
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_slot[0];
    // room for the worst case of two new results
    assign o_room  = (base <= CNT_W'(DEPTH - 2));

    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            if (pop && (k + 1 < DEPTH)) begin
                n_slot[k] = r_slot[k + 1];
            end else begin
                n_slot[k] = r_slot[k];
            end
        end
        for (int k = 0; k < DEPTH; k++) begin
            if ((i_push.count != 2'd0) && (base == CNT_W'(k))) begin
                n_slot[k] = i_push.res0;
            end
            if ((i_push.count == 2'd2) && (base + CNT_W'(1) == CNT_W'(k))) begin
                n_slot[k] = i_push.res1;
            end
        end
        n_cnt = base + CNT_W'(i_push.count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DEPTH; k++) begin
            r_slot[k] <= n_slot[k];
        end
    end

endmodule

`default_nettype wire
